// ----- sv/multi_channel_pipe_fifo_top_macros.svh -----
// Assertion macros for the checker file of the pipe FIFO block.
`ifndef MULTI_CHANNEL_PIPE_FIFO_TOP_MACROS_SVH
`define MULTI_CHANNEL_PIPE_FIFO_TOP_MACROS_SVH

// Checked at every rising edge while reset is released.
`define MCPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also while reset is held.
`define MCPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mcpf_pkg.sv -----
// Shared constants, request and status codes of the pipe FIFO block.
package mcpf_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int BUF_BYTES    = 512;
  localparam int MAX_READ     = 16;

  localparam int CHI_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int FILL_W    = $clog2(BUF_BYTES + 1);
  localparam int CNT_W     = $clog2(MAX_READ + 1);
  localparam int MEM_DEPTH = NUM_CHANNELS * BUF_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  localparam int EOF_BIT = 18;

  localparam logic [2:0] REQ_CREATE      = 3'd0;
  localparam logic [2:0] REQ_READ        = 3'd1;
  localparam logic [2:0] REQ_WRITE       = 3'd2;
  localparam logic [2:0] REQ_CLOSE_READ  = 3'd3;
  localparam logic [2:0] REQ_CLOSE_WRITE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_BROKEN  = 2'd2;
  localparam logic [1:0] ST_NO_FREE = 2'd3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

endpackage

// ----- sv/multi_channel_pipe_fifo_top.sv -----
// Top level of the multi-channel pipe FIFO: channel table, byte memory and request sequencer.
//
// This block keeps a table of byte ring-buffer channels whose bytes live in one synchronous
// single-port memory (NUM_CHANNELS * BUF_BYTES bytes, registered read data); the small
// per-channel table of head and tail pointers, fill levels and open/closed flags sits in
// flip-flops and is reset to all channels inactive. A request transaction enters on the in_
// stream (req_type in in_tuser; chan_id, data_byte and read_count packed in in_tdata) and is
// held in a one-entry request register, so the input side keeps accepting while a finished
// result still waits on the out_ side. Create, write, close and rejected requests produce one
// result transaction each: the request is first registered, then decoded, which updates the
// table and, for a write, writes the byte into memory. A read that returns n bytes issues one
// memory read per cycle and delivers one byte per cycle while the out_ side takes them, and no
// new request is taken until its last byte is out; the single memory port sets that pace.
// Stalls on out_tready simply hold the burst, and the memory output register keeps a byte that
// was fetched but not yet sent. Every request ends with a result that has out_tlast set.
// The byte memory is never cleared:
// a channel only ever reads bytes that were written into it first.
module multi_channel_pipe_fifo_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // chan_id [2:0], data_byte [10:3], read_count [15:11]
  input  logic [mcpf_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type [2:0]
  input  logic [mcpf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status [1:0], new_chan [4:2], out_byte [12:5], done_count [17:13], end_of_file [18],
  // zero fill [23:19]
  output logic [mcpf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // byte_valid [0]
  output logic [mcpf_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                             out_tlast
);
  import mcpf_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  // Request register.
  state_t         state_r, state_nxt;
  logic           req_valid_r, req_valid_nxt;
  logic [2:0]     req_type_r, req_type_nxt;
  logic [2:0]     chan_r, chan_nxt;
  logic [7:0]     data_r, data_nxt;
  logic [4:0]     count_r, count_nxt;

  // Result register.
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [2:0]     out_new_chan_r, out_new_chan_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_byte_valid_r, out_byte_valid_nxt;
  logic [4:0]     out_done_r, out_done_nxt;
  logic           out_eof_r, out_eof_nxt;
  logic           out_last_r, out_last_nxt;

  // Channel table.
  ptr_t                    head_r [NUM_CHANNELS];
  ptr_t                    head_nxt [NUM_CHANNELS];
  ptr_t                    tail_r [NUM_CHANNELS];
  ptr_t                    tail_nxt [NUM_CHANNELS];
  fill_t                   fill_r [NUM_CHANNELS];
  fill_t                   fill_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] active_r, active_nxt;
  logic [NUM_CHANNELS-1:0] rgone_r, rgone_nxt;
  logic [NUM_CHANNELS-1:0] wgone_r, wgone_nxt;

  // Read burst control.
  logic [CNT_W-1:0] rd_total_r, rd_total_nxt;
  logic [CNT_W-1:0] rd_iss_r, rd_iss_nxt;
  logic [CNT_W-1:0] rd_out_r, rd_out_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  // Byte memory port.
  logic [7:0]        byte_store_r [MEM_DEPTH];
  logic [7:0]        mem_rdata_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [ADDR_W-1:0] mem_base;

  // Decode helpers.
  logic             advance;
  logic [CHI_W-1:0] idx;
  logic             in_range;
  logic             free_found;
  logic [CHI_W-1:0] free_idx;
  logic [CNT_W-1:0] want_sat;
  logic [CNT_W-1:0] rd_n;
  logic             issue;
  logic             deliver;
  logic [CNT_W-1:0] rd_out_inc;

  assign in_tready  = !req_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_eof_r, out_done_r, out_byte_r, out_new_chan_r, out_status_r};
  assign out_tuser  = out_byte_valid_r;
  assign out_tlast  = out_last_r;

  // The result register can take a new result this cycle.
  assign advance  = !out_valid_r || out_tready;
  assign idx      = CHI_W'(chan_r);
  assign in_range = (32'(chan_r) < 32'(NUM_CHANNELS));
  assign mem_base = ADDR_W'(ADDR_W'(idx) * ADDR_W'(BUF_BYTES));

  // Lowest inactive channel; the loop runs from the top so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = CHI_W'(i);
      end
    end
  end

  // Burst length: the requested count, saturated, and never more than is stored.
  always_comb begin
    want_sat = (32'(count_r) > 32'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(count_r);
    rd_n     = (32'(want_sat) > 32'(fill_r[idx])) ? CNT_W'(fill_r[idx]) : want_sat;
  end

  assign issue      = (state_r == S_READ) && (rd_iss_r != rd_total_r) && (advance || !rd_pend_r);
  assign deliver    = (state_r == S_READ) && rd_pend_r && advance;
  assign rd_out_inc = rd_out_r + CNT_W'(1);

  always_comb begin
    state_nxt          = state_r;
    req_valid_nxt      = req_valid_r;
    req_type_nxt       = req_type_r;
    chan_nxt           = chan_r;
    data_nxt           = data_r;
    count_nxt          = count_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    out_status_nxt     = out_status_r;
    out_new_chan_nxt   = out_new_chan_r;
    out_byte_nxt       = out_byte_r;
    out_byte_valid_nxt = out_byte_valid_r;
    out_done_nxt       = out_done_r;
    out_eof_nxt        = out_eof_r;
    out_last_nxt       = out_last_r;
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    fill_nxt           = fill_r;
    active_nxt         = active_r;
    rgone_nxt          = rgone_r;
    wgone_nxt          = wgone_r;
    rd_total_nxt       = rd_total_r;
    rd_iss_nxt         = rd_iss_r;
    rd_out_nxt         = rd_out_r;
    rd_pend_nxt        = rd_pend_r;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_addr           = '0;

    if (in_tvalid && !req_valid_r) begin
      req_valid_nxt = 1'b1;
      req_type_nxt  = in_tuser[2:0];
      chan_nxt      = in_tdata[2:0];
      data_nxt      = in_tdata[10:3];
      count_nxt     = in_tdata[15:11];
    end

    case (state_r)
      S_IDLE: begin
        if (req_valid_r && advance) begin
          // Most requests end here with one result.
          req_valid_nxt      = 1'b0;
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ST_OK;
          out_new_chan_nxt   = 3'd0;
          out_byte_nxt       = 8'd0;
          out_byte_valid_nxt = 1'b0;
          out_done_nxt       = 5'd0;
          out_eof_nxt        = 1'b0;
          out_last_nxt       = 1'b1;
          if (req_type_r != REQ_CREATE && !in_range) begin
            out_status_nxt = ST_BAD;
          end else begin
            case (req_type_r)
              REQ_CREATE: begin
                if (free_found) begin
                  head_nxt[free_idx]   = '0;
                  tail_nxt[free_idx]   = '0;
                  fill_nxt[free_idx]   = '0;
                  rgone_nxt[free_idx]  = 1'b0;
                  wgone_nxt[free_idx]  = 1'b0;
                  active_nxt[free_idx] = 1'b1;
                  out_new_chan_nxt     = 3'(free_idx);
                end else begin
                  out_status_nxt = ST_NO_FREE;
                end
              end
              REQ_READ: begin
                if (!active_r[idx]) begin
                  out_status_nxt = ST_BAD;
                end else if (fill_r[idx] == '0) begin
                  out_eof_nxt = wgone_r[idx];
                end else if (rd_n != '0) begin
                  // Bytes to return: hand over to the burst sequencer.
                  req_valid_nxt = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_READ;
                  rd_total_nxt  = rd_n;
                  rd_iss_nxt    = '0;
                  rd_out_nxt    = '0;
                  rd_pend_nxt   = 1'b0;
                end
              end
              REQ_WRITE: begin
                if (!active_r[idx]) begin
                  out_status_nxt = ST_BAD;
                end else if (rgone_r[idx]) begin
                  out_status_nxt = ST_BROKEN;
                end else if (32'(fill_r[idx]) < 32'(BUF_BYTES)) begin
                  mem_we        = 1'b1;
                  mem_addr      = mem_base + ADDR_W'(head_r[idx]);
                  head_nxt[idx] = (head_r[idx] == PTR_W'(BUF_BYTES - 1)) ? '0
                                                                         : head_r[idx] + 1'b1;
                  fill_nxt[idx] = fill_r[idx] + 1'b1;
                  out_done_nxt  = 5'd1;
                end
              end
              REQ_CLOSE_READ: begin
                rgone_nxt[idx] = 1'b1;
                if (wgone_r[idx]) begin
                  active_nxt[idx] = 1'b0;
                end
              end
              REQ_CLOSE_WRITE: begin
                wgone_nxt[idx] = 1'b1;
                if (rgone_r[idx]) begin
                  active_nxt[idx] = 1'b0;
                end
              end
              default: begin
                out_status_nxt = ST_BAD;
              end
            endcase
          end
        end
      end
      S_READ: begin
        // One memory read per cycle unless a fetched byte is held back; a fetched byte waits in the
        // memory output register until the result register can take it.
        if (issue) begin
          mem_re        = 1'b1;
          mem_addr      = mem_base + ADDR_W'(tail_r[idx]);
          tail_nxt[idx] = (tail_r[idx] == PTR_W'(BUF_BYTES - 1)) ? '0 : tail_r[idx] + 1'b1;
          fill_nxt[idx] = fill_r[idx] - 1'b1;
          rd_iss_nxt    = rd_iss_r + CNT_W'(1);
        end
        if (deliver) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ST_OK;
          out_new_chan_nxt   = 3'd0;
          out_byte_nxt       = mem_rdata_r;
          out_byte_valid_nxt = 1'b1;
          out_done_nxt       = 5'(rd_out_inc);
          out_eof_nxt        = 1'b0;
          out_last_nxt       = (rd_out_inc == rd_total_r);
          rd_out_nxt         = rd_out_inc;
          if (rd_out_inc == rd_total_r) begin
            state_nxt     = S_IDLE;
            req_valid_nxt = 1'b0;
          end
        end
        rd_pend_nxt = issue || (rd_pend_r && !advance);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      active_r    <= '0;
      rgone_r     <= '0;
      wgone_r     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      active_r    <= active_nxt;
      rgone_r     <= rgone_nxt;
      wgone_r     <= wgone_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
    end
    req_type_r       <= req_type_nxt;
    chan_r           <= chan_nxt;
    data_r           <= data_nxt;
    count_r          <= count_nxt;
    out_status_r     <= out_status_nxt;
    out_new_chan_r   <= out_new_chan_nxt;
    out_byte_r       <= out_byte_nxt;
    out_byte_valid_r <= out_byte_valid_nxt;
    out_done_r       <= out_done_nxt;
    out_eof_r        <= out_eof_nxt;
    out_last_r       <= out_last_nxt;
    rd_total_r       <= rd_total_nxt;
    rd_iss_r         <= rd_iss_nxt;
    rd_out_r         <= rd_out_nxt;
  end

  // Single-port byte memory; read data stays put until the next read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store_r[mem_addr] <= data_r;
    end else if (mem_re) begin
      mem_rdata_r <= byte_store_r[mem_addr];
    end
  end

endmodule

// ----- sv/mcpf_checker.sv -----
// Port-level checker for the pipe FIFO top level and its bind statement.
`include "multi_channel_pipe_fifo_top_macros.svh"

module mcpf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mcpf_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [mcpf_pkg::IN_USER_W-1:0]   in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mcpf_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [mcpf_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic                             out_tlast
);
  import mcpf_pkg::*;

  // A stalled result stays offered.
  `MCPF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped under stall")

  // A stalled result keeps its payload.
  `MCPF_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "payload changed")

  // A result that carries a byte is a clean read result without end of file.
  `MCPF_ASSERT(a_byte_ok, out_tvalid && out_tuser[0] |-> out_tdata[1:0] == ST_OK && !out_tdata[EOF_BIT], "byte result with bad status")

  // A result without a byte always closes its request.
  `MCPF_ASSERT(a_nobyte_last, out_tvalid && !out_tuser[0] |-> out_tlast, "single result not last")

  // After reset no result is offered and a request can be taken.
  `MCPF_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_tvalid && in_tready, "reset state wrong")

endmodule

bind multi_channel_pipe_fifo_top mcpf_checker u_mcpf_checker (.*);

// ----- sim/multi_channel_pipe_fifo_top_tb.sv -----
// Self-checking testbench of the multi-channel pipe FIFO top level.
//
// Every request transaction that the block accepts is run through a mirror of the channel table
// kept here (byte store, head and tail pointers, fill levels and the three flags per channel).
// The mirror queues the result transactions that the request must cause. Each result transaction
// on the out_ side is then unpacked and compared, field by field, against the oldest entry of
// that queue.
//
// The stimulus has two parts. The opening table comes first. It walks through the rejected
// requests and the reserved request codes, then a create and a short write and read session with
// the empty, zero-count and end-of-file reads. It also covers creates until no channel is free
// and a write into a channel whose read end is closed. Rows whose answer is plain carry it typed
// in. The other rows are predicted by the mirror. A long random part follows. It is mostly
// reads and writes aimed at open channels, mixed with creates, closes and noise. Both handshake
// sides idle at random. The receiver holds off once for a long stretch so that the block backs
// up into its input, and the sender waits twice until every expected result has arrived.
module multi_channel_pipe_fifo_top_tb;
  import mcpf_pkg::*;

  // Request codes that the block does not define; they must be rejected as bad requests.
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQS = 400;
  localparam int SEGMENT     = 40;

  // One result transaction, with the fields of the out_ side.
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] new_chan;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [4:0] done_count;
    logic       eof;
    logic       last;
  } pipe_result_t;

  // One row of the opening table; reply is only used where typed is set.
  typedef struct packed {
    logic [2:0]   req;
    logic [2:0]   chan;
    logic [7:0]   data;
    logic [4:0]   count;
    logic         typed;
    pipe_result_t reply;
  } stim_row_t;

  localparam pipe_result_t R_OK      = '{ST_OK, 3'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1};
  localparam pipe_result_t R_WROTE   = '{ST_OK, 3'd0, 8'h00, 1'b0, 5'd1, 1'b0, 1'b1};
  localparam pipe_result_t R_EOF     = '{ST_OK, 3'd0, 8'h00, 1'b0, 5'd0, 1'b1, 1'b1};
  localparam pipe_result_t R_BAD     = '{ST_BAD, 3'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1};
  localparam pipe_result_t R_BROKEN  = '{ST_BROKEN, 3'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1};
  localparam pipe_result_t R_NO_FREE = '{ST_NO_FREE, 3'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1};

  localparam int OPENING_ROWS = 26;
  localparam stim_row_t OPENING [OPENING_ROWS] = '{
    // Nothing is open after reset, so a read is rejected; so are the reserved codes.
    '{REQ_READ,        3'd3, 8'h00, 5'd0,  1'b1, R_BAD},
    '{REQ_RSVD_FIRST,  3'd1, 8'h00, 5'd0,  1'b1, R_BAD},
    '{REQ_RSVD_LAST,   3'd7, 8'hFF, 5'd31, 1'b1, R_BAD},
    // Closing an end of a channel that is not open sets the flag but leaves it closed.
    '{REQ_CLOSE_READ,  3'd5, 8'h00, 5'd0,  1'b1, R_OK},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, R_OK},
    // An empty read with the write end still open reports no end of file.
    '{REQ_READ,        3'd0, 8'h00, 5'd4,  1'b1, R_OK},
    '{REQ_WRITE,       3'd0, 8'h00, 5'd0,  1'b1, R_WROTE},
    '{REQ_WRITE,       3'd0, 8'hFF, 5'd0,  1'b1, R_WROTE},
    '{REQ_WRITE,       3'd0, 8'hA5, 5'd0,  1'b1, R_WROTE},
    // A zero-count read of a channel that holds bytes returns a single empty result.
    '{REQ_READ,        3'd0, 8'h00, 5'd0,  1'b1, R_OK},
    // The count saturates and is then cut down to the three stored bytes.
    '{REQ_READ,        3'd0, 8'h00, 5'd31, 1'b0, R_OK},
    '{REQ_CLOSE_WRITE, 3'd0, 8'h00, 5'd0,  1'b1, R_OK},
    '{REQ_READ,        3'd0, 8'h00, 5'd2,  1'b1, R_EOF},
    '{REQ_CLOSE_READ,  3'd0, 8'h00, 5'd0,  1'b1, R_OK},
    '{REQ_WRITE,       3'd0, 8'h3C, 5'd0,  1'b1, R_BAD},
    // All channels are closed again, so creates hand them out from the lowest up.
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd1, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd2, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd3, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd4, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd5, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd6, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, '{ST_OK, 3'd7, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{REQ_CREATE,      3'd0, 8'h00, 5'd0,  1'b1, R_NO_FREE},
    // A write after the read end is closed is a broken pipe.
    '{REQ_CLOSE_READ,  3'd2, 8'h00, 5'd0,  1'b1, R_OK},
    '{REQ_WRITE,       3'd2, 8'h5A, 5'd0,  1'b1, R_BROKEN}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  multi_channel_pipe_fifo_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the channel table. Only bytes that were written are ever read back, so the
  // store needs no reset value.
  logic [7:0] mirror_store [MEM_DEPTH];
  ptr_t       mirror_head [NUM_CHANNELS] = '{default: '0};
  ptr_t       mirror_tail [NUM_CHANNELS] = '{default: '0};
  fill_t      mirror_fill [NUM_CHANNELS] = '{default: '0};
  logic       mirror_open [NUM_CHANNELS] = '{default: 1'b0};
  logic       reader_shut [NUM_CHANNELS] = '{default: 1'b0};
  logic       writer_shut [NUM_CHANNELS] = '{default: 1'b0};

  pipe_result_t awaited_replies [$];
  int unsigned  mismatches = 0;

  // The sender and the receiver share these. While calm is set neither side idles at random, and
  // hold_out asks the receiver for one long hold-off, which it gives even in a calm stretch.
  logic calm = 1'b0;
  logic hold_out = 1'b0;

  // Applies one accepted request to the mirror and queues the results that it causes.
  task automatic run_pipe_request(input logic [2:0] req, input logic [2:0] ch,
                                  input logic [7:0] data, input logic [4:0] want);
    pipe_result_t r;
    int unsigned  n;
    logic         found;
    r = '0;
    r.last = 1'b1;
    n = 0;
    found = 1'b0;
    if (req == REQ_CREATE) begin
      r.status = ST_NO_FREE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && !mirror_open[i]) begin
          found          = 1'b1;
          mirror_head[i] = '0;
          mirror_tail[i] = '0;
          mirror_fill[i] = '0;
          reader_shut[i] = 1'b0;
          writer_shut[i] = 1'b0;
          mirror_open[i] = 1'b1;
          r.status       = ST_OK;
          r.new_chan     = 3'(i);
        end
      end
    end else if (req > REQ_CLOSE_WRITE || int'(ch) >= NUM_CHANNELS) begin
      r.status = ST_BAD;
    end else if (req == REQ_READ) begin
      if (!mirror_open[ch]) begin
        r.status = ST_BAD;
      end else if (mirror_fill[ch] == '0) begin
        // An empty read only tells whether the writer has gone away.
        r.eof = writer_shut[ch];
      end else begin
        n = (want > 5'(MAX_READ)) ? MAX_READ : int'(want);
        if (n > int'(mirror_fill[ch])) n = int'(mirror_fill[ch]);
        for (int k = 0; k < int'(n); k++) begin
          r.out_byte   = mirror_store[int'(ch) * BUF_BYTES + int'(mirror_tail[ch])];
          r.byte_valid = 1'b1;
          r.done_count = 5'(k + 1);
          r.last       = (k + 1 == int'(n));
          mirror_tail[ch] = mirror_tail[ch] + 1'b1;
          awaited_replies.push_back(r);
        end
        mirror_fill[ch] = mirror_fill[ch] - FILL_W'(n);
      end
    end else if (req == REQ_WRITE) begin
      if (!mirror_open[ch]) begin
        r.status = ST_BAD;
      end else if (reader_shut[ch]) begin
        r.status = ST_BROKEN;
      end else if (int'(mirror_fill[ch]) < BUF_BYTES) begin
        // A full channel drops the byte and still answers with an ok status.
        mirror_store[int'(ch) * BUF_BYTES + int'(mirror_head[ch])] = data;
        mirror_head[ch] = mirror_head[ch] + 1'b1;
        mirror_fill[ch] = mirror_fill[ch] + 1'b1;
        r.done_count    = 5'd1;
      end
    end else if (req == REQ_CLOSE_READ) begin
      reader_shut[ch] = 1'b1;
      if (writer_shut[ch]) mirror_open[ch] = 1'b0;
    end else begin
      writer_shut[ch] = 1'b1;
      if (reader_shut[ch]) mirror_open[ch] = 1'b0;
    end
    if (n == 0) awaited_replies.push_back(r);
  endtask

  // Offers one request transaction and returns at the edge where it is taken. The valid stays
  // high so that a following request can go out without a gap.
  task automatic offer_request(input logic [2:0] req, input logic [2:0] ch,
                               input logic [7:0] data, input logic [4:0] want);
    in_tuser  <= req;
    in_tdata  <= {want, data, ch};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_pipe_request(req, ch, data, want);
  endtask

  // Most gaps are short, a few are long; none at all in a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (calm || roll < 5) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic sender_gap();
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stops offering until every queued result has come back, then lets the block settle.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Picks a channel, preferring open ones so that most reads and writes get past the checks.
  function automatic logic [2:0] pick_live_channel();
    logic [2:0] ch;
    ch = 3'($urandom_range(0, NUM_CHANNELS - 1));
    for (int t = 0; t < 4; t++) begin
      if (!mirror_open[ch]) ch = 3'($urandom_range(0, NUM_CHANNELS - 1));
    end
    return ch;
  endfunction

  task automatic random_request();
    int unsigned roll;
    logic [2:0]  ch;
    logic [4:0]  want;
    roll = $urandom_range(0, 99);
    ch   = pick_live_channel();
    want = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(MAX_READ + 1, 31))
                                       : 5'($urandom_range(0, MAX_READ));
    if (roll < 45) begin
      offer_request(REQ_WRITE, ch, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    end else if (roll < 72) begin
      offer_request(REQ_READ, ch, 8'($urandom_range(0, 255)), want);
    end else if (roll < 80) begin
      offer_request(REQ_CREATE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), want);
    end else if (roll < 86) begin
      offer_request(REQ_CLOSE_READ, ch, 8'($urandom_range(0, 255)), want);
    end else if (roll < 92) begin
      offer_request(REQ_CLOSE_WRITE, ch, 8'($urandom_range(0, 255)), want);
    end else begin
      // Noise: a reserved code, or any request at any channel with any fields.
      offer_request(($urandom_range(0, 1) == 0) ? 3'($urandom_range(REQ_RSVD_FIRST,
                                                                    REQ_RSVD_LAST))
                                                : 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
    end
  endtask

  // Receiver side: random stalls, mostly short, sometimes long, and one long hold-off on demand.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Result checker: every result transaction must match the oldest queued expectation.
  pipe_result_t seen_reply;
  pipe_result_t due_reply;

  function automatic void check_field(string what, int unsigned due, int unsigned seen);
    if (due != seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, due, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_reply.status     = out_tdata[1:0];
      seen_reply.new_chan   = out_tdata[4:2];
      seen_reply.out_byte   = out_tdata[12:5];
      seen_reply.done_count = out_tdata[17:13];
      seen_reply.eof        = out_tdata[EOF_BIT];
      seen_reply.byte_valid = out_tuser[0];
      seen_reply.last       = out_tlast;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, seen_reply);
        mismatches++;
      end else begin
        due_reply = awaited_replies.pop_front();
        check_field("status", due_reply.status, seen_reply.status);
        check_field("new_chan", due_reply.new_chan, seen_reply.new_chan);
        check_field("out_byte", due_reply.out_byte, seen_reply.out_byte);
        check_field("byte_valid", due_reply.byte_valid, seen_reply.byte_valid);
        check_field("done_count", due_reply.done_count, seen_reply.done_count);
        check_field("end_of_file", due_reply.eof, seen_reply.eof);
        check_field("last", due_reply.last, seen_reply.last);
      end
    end
  end

  // Stimulus and end of the run.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table. A typed reply takes the place of the mirror's answer for that row.
    for (int i = 0; i < OPENING_ROWS; i++) begin
      offer_request(OPENING[i].req, OPENING[i].chan, OPENING[i].data, OPENING[i].count);
      if (OPENING[i].typed) awaited_replies[awaited_replies.size() - 1] = OPENING[i].reply;
      sender_gap();
    end

    // Random traffic in segments, some of them calm. Partway through, the receiver holds off
    // while requests keep coming; later the sender waits for everything to come back.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % SEGMENT == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 150) hold_out = 1'b1;
      if (i == 300) wait_for_drain();
      random_request();
      sender_gap();
    end
    calm = 1'b0;

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_channel_pipe_fifo_top test passed");
    end else begin
      $display("multi_channel_pipe_fifo_top test failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("multi_channel_pipe_fifo_top test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/mcpf_pkg.sv
sv/multi_channel_pipe_fifo_top.sv
sv/mcpf_checker.sv
sim/multi_channel_pipe_fifo_top_tb.sv
